// ===== src/qstc_pkg.sv =====
`timescale 1ns / 1ps
package qstc_pkg;

	localparam int MAG_BITS_DEF = 14;

	typedef enum logic {
		OP_PACK   = 1'b0,
		OP_UNPACK = 1'b1
	} qstc_op_t;

	// index of the k-th kept component when component big is dropped
	function automatic logic [1:0] kept_slot(input logic [1:0] big, input logic [1:0] k);
		logic [1:0] slot;
		slot = 2'd0;
		case (k)
			2'd0: slot = (big == 2'd0) ? 2'd1 : 2'd0;
			2'd1: slot = (big <= 2'd1) ? 2'd2 : 2'd1;
			2'd2: slot = (big <= 2'd2) ? 2'd3 : 2'd2;
			default: slot = 2'd0;
		endcase
		return slot;
	endfunction

endpackage

// ===== src/quaternion_smallest_three_codec_top.sv =====
// input to result: stages 1 to 3, the square-root stages and the output register
// throughput: one item per cycle unless m_axis_tready stalls; square root: one bit per stage
// every stage holds its item under backpressure and refills bubbles
// reset: arst_n clears all valid bits at once, no other state
`timescale 1ns / 1ps
module quaternion_smallest_three_codec_top
	import qstc_pkg::*;
#(
	parameter int MAG_BITS = MAG_BITS_DEF,
	localparam int W     = MAG_BITS + 1,
	localparam int IN_B  = 7 * W + 3,
	localparam int IN_W  = ((IN_B + 7) / 8) * 8,
	localparam int OUT_B = 6 + 3 * MAG_BITS + 4 * W,
	localparam int OUT_W = ((OUT_B + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// comp_x, comp_y, comp_z, comp_w, dropped_index, dropped_negative,
	// kept_first, kept_second, kept_third
	input  logic [IN_W-1:0]  s_axis_tdata,
	// opcode
	input  logic             s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// largest_index, largest_negative, mag_first, mag_second, mag_third,
	// neg_first, neg_second, neg_third, quat_x, quat_y, quat_z, quat_w
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int RW     = 2 * MAG_BITS;
	localparam int SIDE_W = 13 + 6 * MAG_BITS;
	localparam logic [MAG_BITS-1:0] ONE = {MAG_BITS{1'b1}};
	localparam logic [RW-1:0] ONE_W  = {{MAG_BITS{1'b0}}, ONE};
	localparam logic [RW-1:0] ONE_SQ = ONE_W * ONE_W;

	function automatic logic [W-1:0] abs_val(input logic [W-1:0] x);
		return x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
	endfunction

	function automatic logic [MAG_BITS-1:0] sat_mag(input logic [W-1:0] a);
		return (a > {1'b0, ONE}) ? ONE : a[MAG_BITS-1:0];
	endfunction

	// input unpacking
	logic [W-1:0] comp_in [4];
	logic [W-1:0] kept_in [3];
	logic [1:0]   drop_in;
	logic         dneg_in;

	assign {kept_in[2], kept_in[1], kept_in[0], dneg_in, drop_in,
		comp_in[3], comp_in[2], comp_in[1], comp_in[0]} = s_axis_tdata[IN_B-1:0];

	// stage 1: magnitudes and saturation
	logic                v_s1;
	qstc_op_t            op_s1;
	logic [W-1:0]        amag_s1 [4];
	logic [MAG_BITS-1:0] smag_s1 [4];
	logic [3:0]          sgn_s1;
	logic [MAG_BITS-1:0] kmag_s1 [3];
	logic [2:0]          ksgn_s1;
	logic [1:0]          drop_s1;
	logic                dneg_s1;
	logic                en_s1;

	// stage 2: largest search, squares
	logic                v_s2;
	qstc_op_t            op_s2;
	logic [1:0]          big_s2;
	logic [MAG_BITS-1:0] smag_s2 [4];
	logic [3:0]          sgn_s2;
	logic [RW-1:0]       sq_s2 [3];
	logic [MAG_BITS-1:0] kmag_s2 [3];
	logic [2:0]          ksgn_s2;
	logic [1:0]          drop_s2;
	logic                dneg_s2;
	logic                en_s2;

	// stage 3: kept selection, radicand
	logic                v_s3;
	qstc_op_t            op_s3;
	logic [1:0]          lidx_s3;
	logic                lneg_s3;
	logic [MAG_BITS-1:0] mag_s3 [3];
	logic [2:0]          neg_s3;
	logic [MAG_BITS-1:0] kmag_s3 [3];
	logic [2:0]          ksgn_s3;
	logic [1:0]          drop_s3;
	logic                dneg_s3;
	logic [RW-1:0]       rad_s3;
	logic                en_s3;

	// root pipeline
	logic                sr_valid [MAG_BITS+1];
	logic                sr_ready [MAG_BITS+1];
	logic [RW-1:0]       sr_rem   [MAG_BITS+1];
	logic [RW-1:0]       sr_res   [MAG_BITS+1];
	logic [SIDE_W-1:0]   sr_side  [MAG_BITS+1];

	// output register
	logic                out_valid_q;
	logic [OUT_B-1:0]    out_data_q;
	logic                en_out;

	assign en_out = !out_valid_q || m_axis_tready;
	assign en_s3  = !v_s3 || sr_ready[0];
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid_q <= sr_valid[MAG_BITS];
			end
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1   <= qstc_op_t'(s_axis_tuser);
			drop_s1 <= drop_in;
			dneg_s1 <= dneg_in;
			for (int i = 0; i < 4; i++) begin
				amag_s1[i] <= abs_val(comp_in[i]);
				smag_s1[i] <= sat_mag(abs_val(comp_in[i]));
				sgn_s1[i]  <= comp_in[i][W-1];
			end
			for (int i = 0; i < 3; i++) begin
				kmag_s1[i] <= sat_mag(abs_val(kept_in[i]));
				ksgn_s1[i] <= kept_in[i][W-1];
			end
		end
	end

	// stage 2: lower index wins ties
	logic [1:0]   w01, w23, big_c;
	logic [W-1:0] m01, m23;

	always_comb begin
		w01   = (amag_s1[1] > amag_s1[0]) ? 2'd1 : 2'd0;
		m01   = (amag_s1[1] > amag_s1[0]) ? amag_s1[1] : amag_s1[0];
		w23   = (amag_s1[3] > amag_s1[2]) ? 2'd3 : 2'd2;
		m23   = (amag_s1[3] > amag_s1[2]) ? amag_s1[3] : amag_s1[2];
		big_c = (m23 > m01) ? w23 : w01;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2   <= op_s1;
			big_s2  <= big_c;
			sgn_s2  <= sgn_s1;
			ksgn_s2 <= ksgn_s1;
			drop_s2 <= drop_s1;
			dneg_s2 <= dneg_s1;
			for (int i = 0; i < 4; i++) begin
				smag_s2[i] <= smag_s1[i];
			end
			for (int i = 0; i < 3; i++) begin
				kmag_s2[i] <= kmag_s1[i];
				sq_s2[i]   <= {{MAG_BITS{1'b0}}, kmag_s1[i]} * {{MAG_BITS{1'b0}}, kmag_s1[i]};
			end
		end
	end

	// stage 3
	logic [RW+1:0]       sum_c;
	logic [RW-1:0]       rad_c;
	logic [1:0]          slot_c [3];

	always_comb begin
		sum_c = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
		rad_c = (sum_c >= {2'b00, ONE_SQ}) ? '0 : (ONE_SQ - sum_c[RW-1:0]);
		for (int i = 0; i < 3; i++) begin
			slot_c[i] = kept_slot(big_s2, 2'(i));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3   <= op_s2;
			ksgn_s3 <= ksgn_s2;
			drop_s3 <= drop_s2;
			dneg_s3 <= dneg_s2;
			rad_s3  <= rad_c;
			for (int i = 0; i < 3; i++) begin
				kmag_s3[i] <= kmag_s2[i];
			end
			if (op_s2 == OP_PACK) begin
				lidx_s3 <= big_s2;
				lneg_s3 <= sgn_s2[big_s2];
				for (int i = 0; i < 3; i++) begin
					mag_s3[i] <= smag_s2[slot_c[i]];
					neg_s3[i] <= sgn_s2[slot_c[i]];
				end
			end else begin
				lidx_s3 <= 2'd0;
				lneg_s3 <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					mag_s3[i] <= '0;
					neg_s3[i] <= 1'b0;
				end
			end
		end
	end

	assign sr_valid[0] = v_s3;
	assign sr_rem[0]   = rad_s3;
	assign sr_res[0]   = '0;
	assign sr_side[0]  = {op_s3, lidx_s3, lneg_s3, mag_s3[0], mag_s3[1], mag_s3[2], neg_s3,
		kmag_s3[0], kmag_s3[1], kmag_s3[2], ksgn_s3, drop_s3, dneg_s3};
	assign sr_ready[MAG_BITS] = en_out;

	for (genvar k = 0; k < MAG_BITS; k++) begin : g_root
		qstc_sqrt_stage #(
			.MAG_BITS (MAG_BITS),
			.STEP     (k),
			.SIDE_W   (SIDE_W)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sr_valid[k]),
			.in_ready  (sr_ready[k]),
			.in_rem    (sr_rem[k]),
			.in_res    (sr_res[k]),
			.in_side   (sr_side[k]),
			.out_valid (sr_valid[k+1]),
			.out_ready (sr_ready[k+1]),
			.out_rem   (sr_rem[k+1]),
			.out_res   (sr_res[k+1]),
			.out_side  (sr_side[k+1])
		);
	end

	// final: rounding, sign, placement
	logic                f_op;
	logic [1:0]          f_lidx;
	logic                f_lneg;
	logic [MAG_BITS-1:0] f_mag [3];
	logic [2:0]          f_neg;
	logic [MAG_BITS-1:0] f_kmag [3];
	logic [2:0]          f_ksgn;
	logic [1:0]          f_drop;
	logic                f_dneg;
	logic [MAG_BITS-1:0] root_c;
	logic [W-1:0]        big_v;
	logic [W-1:0]        quat_c [4];
	logic [W-1:0]        kv;

	assign {f_op, f_lidx, f_lneg, f_mag[0], f_mag[1], f_mag[2], f_neg,
		f_kmag[0], f_kmag[1], f_kmag[2], f_ksgn, f_drop, f_dneg} = sr_side[MAG_BITS];

	always_comb begin
		root_c = sr_res[MAG_BITS][MAG_BITS-1:0];
		if (sr_rem[MAG_BITS] > {{MAG_BITS{1'b0}}, root_c}) begin
			root_c = root_c + {{(MAG_BITS-1){1'b0}}, 1'b1};
		end
		big_v = {1'b0, root_c};
		if (f_dneg) begin
			big_v = ~big_v + {{(W-1){1'b0}}, 1'b1};
		end
		for (int i = 0; i < 4; i++) begin
			quat_c[i] = '0;
		end
		kv = '0;
		if (qstc_op_t'(f_op) == OP_UNPACK) begin
			for (int i = 0; i < 3; i++) begin
				kv = {1'b0, f_kmag[i]};
				if (f_ksgn[i]) begin
					kv = ~kv + {{(W-1){1'b0}}, 1'b1};
				end
				quat_c[kept_slot(f_drop, 2'(i))] = kv;
			end
			quat_c[f_drop] = big_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_data_q <= {quat_c[3], quat_c[2], quat_c[1], quat_c[0], f_neg[2], f_neg[1],
				f_neg[0], f_mag[2], f_mag[1], f_mag[0], f_lneg, f_lidx};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

endmodule

// ===== src/qstc_sqrt_stage.sv =====
`timescale 1ns / 1ps
module qstc_sqrt_stage
	import qstc_pkg::*;
#(
	parameter int MAG_BITS = MAG_BITS_DEF,
	parameter int STEP     = 0,
	parameter int SIDE_W   = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2*MAG_BITS-1:0]   in_rem,
	input  logic [2*MAG_BITS-1:0]   in_res,
	input  logic [SIDE_W-1:0]       in_side,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2*MAG_BITS-1:0]   out_rem,
	output logic [2*MAG_BITS-1:0]   out_res,
	output logic [SIDE_W-1:0]       out_side
);

	localparam int RW    = 2 * MAG_BITS;
	localparam int SHIFT = 2 * (MAG_BITS - 1 - STEP);
	localparam logic [RW-1:0] BIT_V = {{(RW-1){1'b0}}, 1'b1} << SHIFT;

	logic          valid_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] res_q;
	logic [SIDE_W-1:0] side_q;

	logic          en;
	logic [RW:0]   trial;
	logic          take;
	logic [RW-1:0] rem_n;
	logic [RW-1:0] res_n;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	// one root bit per stage
	always_comb begin
		trial = {1'b0, in_res} + {1'b0, BIT_V};
		take  = ({1'b0, in_rem} >= trial);
		if (take) begin
			rem_n = in_rem - trial[RW-1:0];
			res_n = (in_res >> 1) + BIT_V;
		end else begin
			rem_n = in_rem;
			res_n = in_res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_n;
			res_q  <= res_n;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_res   = res_q;
	assign out_side  = side_q;

endmodule
